### src/cscp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscp_pkg: shared types and constants of the CAN serial command parser
// Parse states, result kinds, opcodes and register addresses.
// ----------------------------------------------------------------------------
package cscp_pkg;

    localparam int unsigned BusLimitDefault = 2;
    localparam int unsigned MaxResults      = 17;
    localparam logic [7:0]  CmdStart        = 8'hF1;
    localparam logic [7:0]  BinStart        = 8'hE7;
    localparam logic [19:0] SpeedMax        = 20'd1000000;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_COMMAND  = 4'd1,
        ST_SEND     = 4'd2,
        ST_SKIP_ONE = 4'd3,
        ST_SETUP    = 4'd5,
        ST_SYSTYPE  = 4'd7,
        ST_ECHO     = 4'd8,
        ST_EXT      = 4'd9
    } t_state;

    typedef enum logic [2:0] {
        K_REPLY  = 3'd0,
        K_SEND   = 3'd1,
        K_ECHO   = 3'd2,
        K_SETUP  = 3'd3,
        K_SYSTYP = 3'd4,
        K_BINARY = 3'd5
    } t_kind;

    localparam logic [7:0] OP_SEND     = 8'd0;
    localparam logic [7:0] OP_TIME     = 8'd1;
    localparam logic [7:0] OP_DIG      = 8'd2;
    localparam logic [7:0] OP_SETUP_ST = 8'd3;
    localparam logic [7:0] OP_SKIP4    = 8'd4;
    localparam logic [7:0] OP_BUSSET   = 8'd5;
    localparam logic [7:0] OP_BUSPAR   = 8'd6;
    localparam logic [7:0] OP_INFO     = 8'd7;
    localparam logic [7:0] OP_SKIP8    = 8'd8;
    localparam logic [7:0] OP_KEEP     = 8'd9;
    localparam logic [7:0] OP_SYSTYPE  = 8'd10;
    localparam logic [7:0] OP_ECHO     = 8'd11;
    localparam logic [7:0] OP_NBUS     = 8'd12;
    localparam logic [7:0] OP_EXTBUS   = 8'd13;
    localparam logic [7:0] OP_EXTSKIP  = 8'd14;

    localparam logic [0:0] REG_BUSCNT = 1'b0;
    localparam logic [0:0] REG_BUILD  = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [30:0] frame_id;
        logic        frame_extended;
        logic [1:0]  bus_index;
        logic [3:0]  frame_length;
        logic [63:0] frame_data;
        logic        bus_enable;
        logic        bus_listen_only;
        logic [19:0] bus_speed;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] timestamp_us;
    } t_item;

endpackage

### src/cscp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscp_if: valid/ready channel
// Carries one payload of type T per accepted request.
// ----------------------------------------------------------------------------
interface cscp_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/can_serial_command_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_serial_command_parser: host serial command parser for a CAN adapter
// Decodes host bytes into frames, bus setups, system types, binary flags and canned replies.
// ----------------------------------------------------------------------------
// Each accepted byte is decoded into a small burst of results (up to 17),
// held in a result buffer and then sent one result per cycle while the
// receiver is ready; the single output port drains the burst. The next byte
// is accepted in the same cycle that the last result of the burst leaves.
module can_serial_command_parser
    import cscp_pkg::*;
#(
    parameter int unsigned BUS_LIMIT = BusLimitDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cscp_if.sink        i_in,
    cscp_if.source      o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MaxResults + 1);

    // configuration
    logic [2:0]  r_bus_cnt;
    logic [15:0] r_build;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_cnt <= 3'd2;
            r_build   <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_BUSCNT) r_bus_cnt <= pwdata[2:0];
            else                        r_build   <= pwdata[15:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_BUSCNT) prdata[2:0] = r_bus_cnt;
        else                        prdata[15:0] = r_build;
    end

    // parser state
    t_state      r_state, n_state;
    logic [3:0]  r_step, n_step;
    logic [31:0] r_asm, n_asm;
    logic [30:0] r_fid, n_fid;
    logic        r_fext, n_fext;
    logic [1:0]  r_fbus, n_fbus;
    logic [3:0]  r_flen, n_flen;
    logic [63:0] r_fdat, n_fdat;
    logic [1:0]  r_ben, n_ben, r_blis, n_blis;
    logic [19:0] r_brate [2];
    logic [19:0] n_brate [2];
    logic [7:0]  r_systype, n_systype;
    logic        r_binary, n_binary;

    // result burst buffer
    logic [7:0]  r_rbytes [MaxResults];
    logic [7:0]  n_rbytes [MaxResults];
    t_result     r_single, n_single;
    logic        r_is_reply, n_is_reply;
    logic [CW-1:0] r_cnt, n_cnt, r_idx;

    logic in_take, out_take, busy_last;
    assign out_take  = o_out.valid && o_out.ready;
    assign busy_last = (r_idx == r_cnt - CW'(1));
    assign i_in.ready = (r_cnt == '0) || (out_take && busy_last);
    assign in_take = i_in.valid && i_in.ready;

    logic [7:0]  b;
    logic [31:0] now;
    assign b   = i_in.payload.rx_byte;
    assign now = i_in.payload.timestamp_us;

    function automatic logic [19:0] clamp_speed(input logic [31:0] w);
        return (w[19:0] > SpeedMax) ? SpeedMax : w[19:0];
    endfunction

    logic [31:0] asm_w;
    logic [5:0]  sh;
    logic        bsel, allow;

    // next state: decode one byte
    always_comb begin
        n_state = r_state; n_step = r_step; n_asm = r_asm;
        n_fid = r_fid; n_fext = r_fext; n_fbus = r_fbus; n_flen = r_flen;
        n_fdat = r_fdat; n_ben = r_ben; n_blis = r_blis; n_brate = r_brate;
        n_systype = r_systype; n_binary = r_binary;
        n_rbytes = r_rbytes; n_single = '0; n_is_reply = 1'b0; n_cnt = '0;
        asm_w = '0; sh = '0; bsel = 1'b0; allow = 1'b1;
        for (int k = 0; k < MaxResults; k++) n_rbytes[k] = '0;
        unique case (r_state)
            ST_COMMAND: begin
                n_state = ST_IDLE;
                n_is_reply = 1'b1;
                n_rbytes[0] = CmdStart;
                n_rbytes[1] = b;
                unique case (b)
                    OP_SEND, OP_ECHO: begin
                        n_state = (b == OP_SEND) ? ST_SEND : ST_ECHO;
                        n_step = '0; n_fdat = '0;
                    end
                    OP_TIME: begin
                        n_state = ST_SKIP_ONE; n_step = '0;
                        n_rbytes[2] = now[7:0];   n_rbytes[3] = now[15:8];
                        n_rbytes[4] = now[23:16]; n_rbytes[5] = now[31:24];
                        n_cnt = CW'(6);
                    end
                    OP_DIG: begin
                        n_rbytes[3] = CmdStart ^ OP_DIG;
                        n_cnt = CW'(4);
                    end
                    OP_SETUP_ST: begin
                        n_rbytes[16] = CmdStart ^ OP_SETUP_ST;
                        n_cnt = CW'(17);
                    end
                    OP_SKIP4, OP_SKIP8: begin
                        n_state = ST_SKIP_ONE; n_step = '0;
                    end
                    OP_BUSSET: begin
                        n_state = ST_SETUP; n_step = '0;
                    end
                    OP_BUSPAR: begin
                        for (int k = 0; k < 2; k++) begin
                            n_rbytes[2+5*k] = {3'b0, r_blis[k], 3'b0, r_ben[k]};
                            n_rbytes[3+5*k] = r_brate[k][7:0];
                            n_rbytes[4+5*k] = r_brate[k][15:8];
                            n_rbytes[5+5*k] = {4'b0, r_brate[k][19:16]};
                        end
                        n_cnt = CW'(12);
                    end
                    OP_INFO: begin
                        n_rbytes[2] = r_build[7:0];
                        n_rbytes[3] = r_build[15:8];
                        n_rbytes[4] = 8'h20;
                        n_cnt = CW'(8);
                    end
                    OP_KEEP: begin
                        n_rbytes[2] = 8'hDE; n_rbytes[3] = 8'hAD;
                        n_cnt = CW'(4);
                    end
                    OP_SYSTYPE: begin
                        n_state = ST_SYSTYPE; n_step = '0;
                    end
                    OP_NBUS: begin
                        n_rbytes[2] = {5'b0, r_bus_cnt};
                        n_cnt = CW'(3);
                    end
                    OP_EXTBUS: n_cnt = CW'(17);
                    OP_EXTSKIP: begin
                        n_state = ST_EXT; n_step = '0;
                    end
                    default: n_state = ST_COMMAND;
                endcase
            end
            ST_SEND, ST_ECHO: begin
                n_step = r_step + 4'd1;
                if (r_step < 4'd4) begin
                    asm_w = (r_step == 4'd0) ? 32'(b)
                          : (r_asm | (32'(b) << {r_step[1:0], 3'b000}));
                    n_asm = asm_w;
                    if (r_step == 4'd3) begin
                        n_fext = asm_w[31];
                        n_fid  = asm_w[30:0];
                    end
                end else if (r_step == 4'd4) begin
                    n_fbus = (r_state == ST_ECHO) ? {1'b0, b[0]} : b[1:0];
                end else if (r_step == 4'd5) begin
                    n_flen = (b[3:0] > 4'd8) ? 4'd8 : b[3:0];
                end else if ({1'b0, r_step} < {1'b0, r_flen} + 5'd6) begin
                    sh = {r_step[2:0] - 3'd6, 3'b000};
                    n_fdat = (r_fdat & ~(64'hFF << sh)) | (64'(b) << sh);
                end else begin
                    n_state = ST_IDLE;
                    n_single.frame_id = r_fid;
                    n_single.frame_extended = r_fext;
                    n_single.bus_index = r_fbus;
                    n_single.frame_length = r_flen;
                    n_single.frame_data = r_fdat;
                    if (r_state == ST_ECHO) begin
                        n_single.kind = K_ECHO; n_cnt = CW'(1);
                    end else begin
                        n_single.kind = K_SEND;
                        if (32'(r_fbus) < BUS_LIMIT) n_cnt = CW'(1);
                    end
                end
            end
            ST_SKIP_ONE: n_state = ST_IDLE;
            ST_SETUP: begin
                n_step = r_step + 4'd1;
                if (r_step < 4'd8) begin
                    asm_w = (r_step[1:0] == 2'd0) ? 32'(b)
                          : (r_asm | (32'(b) << {r_step[1:0], 3'b000}));
                    n_asm = asm_w;
                    if (r_step[1:0] == 2'd3) begin
                        bsel  = r_step[2];
                        allow = !bsel || (r_bus_cnt > 3'd1);
                        if (asm_w != '0 && allow) begin
                            if (asm_w[31]) begin
                                n_ben[bsel]  = asm_w[30];
                                n_blis[bsel] = asm_w[29];
                            end else begin
                                n_ben[bsel] = 1'b1;
                            end
                            n_brate[bsel] = clamp_speed(asm_w);
                        end else begin
                            n_ben[bsel] = 1'b0;
                        end
                        n_single.kind = K_SETUP;
                        n_single.bus_index = {1'b0, bsel};
                        n_single.bus_enable = n_ben[bsel];
                        n_single.bus_listen_only = n_blis[bsel];
                        n_single.bus_speed = n_brate[bsel];
                        n_cnt = CW'(1);
                        if (bsel) n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SYSTYPE: begin
                n_systype = b;
                n_single.kind = K_SYSTYP;
                n_single.data_byte = b;
                n_cnt = CW'(1);
                n_state = ST_IDLE;
            end
            ST_EXT: begin
                if (r_step >= 4'd11) n_state = ST_IDLE;
                n_step = r_step + 4'd1;
            end
            default: begin
                n_state = ST_IDLE;
                if (b == CmdStart) begin
                    n_state = ST_COMMAND;
                end else if (b == BinStart) begin
                    n_binary = 1'b1;
                    n_single.kind = K_BINARY;
                    n_single.data_byte = 8'd1;
                    n_cnt = CW'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_step <= '0; r_asm <= '0; r_fid <= '0;
            r_fext <= 1'b0; r_fbus <= '0; r_flen <= '0; r_fdat <= '0;
            r_ben <= '0; r_blis <= '0; r_brate[0] <= '0; r_brate[1] <= '0;
            r_systype <= '0; r_binary <= 1'b0; r_cnt <= '0; r_idx <= '0;
        end else if (in_take) begin
            r_state <= n_state; r_step <= n_step; r_asm <= n_asm;
            r_fid <= n_fid; r_fext <= n_fext; r_fbus <= n_fbus;
            r_flen <= n_flen; r_fdat <= n_fdat; r_ben <= n_ben;
            r_blis <= n_blis; r_brate <= n_brate; r_systype <= n_systype;
            r_binary <= n_binary; r_cnt <= n_cnt; r_idx <= '0;
        end else if (out_take) begin
            // advance through the burst, drop it after the last result
            if (busy_last) r_cnt <= '0;
            else           r_idx <= r_idx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_rbytes   <= n_rbytes;
            r_single   <= n_single;
            r_is_reply <= n_is_reply;
        end
    end

    // outputs
    always_comb begin
        o_out.valid = (r_cnt != '0);
        if (r_is_reply) begin
            o_out.payload = '0;
            o_out.payload.kind = K_REPLY;
            o_out.payload.data_byte = r_rbytes[r_idx[$clog2(MaxResults)-1:0]];
        end else begin
            o_out.payload = r_single;
        end
        o_out.payload.last = busy_last;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_idx < r_cnt)
        else $error("burst index beyond count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |-> (r_cnt == '0) || (out_take && busy_last))
        else $error("byte taken while burst pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !r_is_reply) |-> r_cnt == CW'(1))
        else $error("non-reply burst longer than one");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> $stable(r_idx))
        else $error("index moved while stalled");

endmodule

### sim/can_serial_command_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_serial_command_parser_tb: self-checking bench for the command parser
// Feeds host bytes with random idling on both sides, predicts every result
// burst in a scoreboard and compares each accepted result as a whole.
// ----------------------------------------------------------------------------
module can_serial_command_parser_tb;
    import cscp_pkg::*;

    localparam int WatchdogLimit = 1000;

    class cmd_scoreboard;
        t_result   pending[$];
        int        errors;
        logic [2:0]  bus_count;
        logic [15:0] build_num;
        t_state      state;
        logic [3:0]  step;
        logic [31:0] word;
        logic [30:0] fid;
        logic        fext;
        logic [1:0]  fbus;
        logic [3:0]  flen;
        logic [63:0] fdata;
        logic        en[2];
        logic        lis[2];
        logic [19:0] rate[2];
        logic [7:0]  sys_type;
        logic [7:0]  xsum;
        t_result     burst[$];

        function void clear_state();
            bus_count = 3'd2; build_num = 16'd0;
            state = ST_IDLE; step = 0; word = 0; fid = 0; fext = 0;
            fbus = 0; flen = 0; fdata = 0; sys_type = 0; errors = 0;
            xsum = 0;
            for (int k = 0; k < 2; k++) begin
                en[k] = 0; lis[k] = 0; rate[k] = 0;
            end
        endfunction

        function void push(t_result r);
            burst.push_back(r);
        endfunction

        function void reply(logic [7:0] b);
            t_result r;
            r = '0; r.kind = K_REPLY; r.data_byte = b;
            xsum ^= b;
            push(r);
        endfunction

        function void frame_out(t_kind k);
            t_result r;
            r = '0; r.kind = k; r.frame_id = fid; r.frame_extended = fext;
            r.bus_index = fbus; r.frame_length = flen; r.frame_data = fdata;
            push(r);
        endfunction

        function void setup_bus(int b, logic [31:0] w, bit allowed);
            t_result r;
            logic [19:0] spd;
            spd = w[19:0];
            if (spd > SpeedMax) spd = SpeedMax;
            if (w != 0 && allowed) begin
                if (w[31]) begin
                    en[b] = w[30]; lis[b] = w[29];
                end else begin
                    en[b] = 1;
                end
                rate[b] = spd;
            end else begin
                en[b] = 0;
            end
            r = '0; r.kind = K_SETUP; r.bus_index = b[1:0];
            r.bus_enable = en[b]; r.bus_listen_only = lis[b]; r.bus_speed = rate[b];
            push(r);
        endfunction

        function void frame_byte(logic [7:0] b, bit echo);
            if (step < 4) begin
                if (step == 0) word = {24'd0, b};
                else word |= {24'd0, b} << (8 * step);
                if (step == 3) begin
                    fext = word[31]; fid = word[30:0];
                end
            end else if (step == 4) begin
                fbus = echo ? {1'b0, b[0]} : b[1:0];
            end else if (step == 5) begin
                flen = (b[3:0] > 8) ? 4'd8 : b[3:0];
            end else if (step < {1'b0, flen} + 5'd6) begin
                fdata[8 * ((step - 6) & 7) +: 8] = b;
            end else begin
                state = ST_IDLE;
                if (echo) frame_out(K_ECHO);
                else if (fbus < BusLimitDefault) frame_out(K_SEND);
            end
            step = step + 1;
        endfunction

        function void command(logic [7:0] op, logic [31:0] now);
            xsum = 0;
            case (op)
                OP_SEND, OP_ECHO: begin
                    state = (op == OP_SEND) ? ST_SEND : ST_ECHO;
                    step = 0; fdata = 0;
                end
                OP_TIME: begin
                    state = ST_SKIP_ONE; step = 0;
                    reply(CmdStart); reply(OP_TIME);
                    for (int k = 0; k < 4; k++) reply(now[8 * k +: 8]);
                end
                OP_DIG: begin
                    reply(CmdStart); reply(OP_DIG); reply(8'd0); reply(xsum);
                    state = ST_IDLE;
                end
                OP_SETUP_ST: begin
                    reply(CmdStart); reply(OP_SETUP_ST);
                    repeat (14) reply(8'd0);
                    reply(xsum);
                    state = ST_IDLE;
                end
                OP_SKIP4, OP_SKIP8: begin
                    state = ST_SKIP_ONE; step = 0;
                end
                OP_BUSSET: begin
                    state = ST_SETUP; step = 0;
                end
                OP_BUSPAR: begin
                    reply(CmdStart); reply(OP_BUSPAR);
                    for (int k = 0; k < 2; k++) begin
                        reply({3'd0, lis[k], 3'd0, en[k]});
                        reply(rate[k][7:0]); reply(rate[k][15:8]);
                        reply({4'd0, rate[k][19:16]}); reply(8'd0);
                    end
                    state = ST_IDLE;
                end
                OP_INFO: begin
                    reply(CmdStart); reply(OP_INFO);
                    reply(build_num[7:0]); reply(build_num[15:8]);
                    reply(8'h20); reply(8'd0); reply(8'd0); reply(8'd0);
                    state = ST_IDLE;
                end
                OP_KEEP: begin
                    reply(CmdStart); reply(OP_KEEP); reply(8'hDE); reply(8'hAD);
                    state = ST_IDLE;
                end
                OP_SYSTYPE: begin
                    state = ST_SYSTYPE; step = 0;
                end
                OP_NBUS: begin
                    reply(CmdStart); reply(OP_NBUS); reply({5'd0, bus_count});
                    state = ST_IDLE;
                end
                OP_EXTBUS: begin
                    reply(CmdStart); reply(OP_EXTBUS);
                    repeat (15) reply(8'd0);
                    state = ST_IDLE;
                end
                OP_EXTSKIP: begin
                    state = ST_EXT; step = 0;
                end
                default: ;
            endcase
        endfunction

        // note an accepted request and queue its predicted burst
        function void note_request(t_item it);
            t_result r;
            logic [7:0] b;
            b = it.rx_byte;
            burst.delete();
            case (state)
                ST_COMMAND: command(b, it.timestamp_us);
                ST_SEND:    frame_byte(b, 0);
                ST_ECHO:    frame_byte(b, 1);
                ST_SKIP_ONE: state = ST_IDLE;
                ST_SETUP: begin
                    if (step < 8) begin
                        if (step[1:0] == 0) word = {24'd0, b};
                        else word |= {24'd0, b} << (8 * step[1:0]);
                        if (step == 3) setup_bus(0, word, 1);
                        else if (step == 7) begin
                            setup_bus(1, word, bus_count > 1);
                            state = ST_IDLE;
                        end
                    end else begin
                        state = ST_IDLE;
                    end
                    step = step + 1;
                end
                ST_SYSTYPE: begin
                    sys_type = b;
                    r = '0; r.kind = K_SYSTYP; r.data_byte = b;
                    push(r);
                    state = ST_IDLE;
                end
                ST_EXT: begin
                    if (step >= 11) state = ST_IDLE;
                    step = step + 1;
                end
                default: begin
                    state = ST_IDLE;
                    if (b == CmdStart) state = ST_COMMAND;
                    else if (b == BinStart) begin
                        r = '0; r.kind = K_BINARY; r.data_byte = 8'd1;
                        push(r);
                    end
                end
            endcase
            if (burst.size() > 0) burst[burst.size() - 1].last = 1;
            foreach (burst[k]) pending.push_back(burst[k]);
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result exp=none act=%h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                $display("%0t: mismatch exp=%h act=%h", $time, exp_r, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    cscp_if #(.T(t_item))   in_ch ();
    cscp_if #(.T(t_result)) out_ch ();

    can_serial_command_parser dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    cmd_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;
    t_item byte_q[$];

    // receiver side: random stall, sample on rising edge
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
            if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.payload);
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [0:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
        if (idx == REG_BUSCNT) sb.bus_count = val[2:0];
        else sb.build_num = val[15:0];
    endtask

    task automatic push_byte(logic [7:0] v);
        t_item it;
        it.rx_byte = v;
        it.timestamp_us = $urandom();
        byte_q.push_back(it);
    endtask

    function automatic logic [31:0] bus_word();
        logic [31:0] w;
        case ($urandom_range(3))
            0: w = '0;
            1: w = {1'b1, 2'($urandom_range(3)), 9'd0, 20'($urandom_range(1048575))};
            2: w = 32'($urandom_range(1000000));
            default: w = $urandom();
        endcase
        return w;
    endfunction

    // queue whole commands until about count more bytes are waiting
    task automatic gen_commands(int count);
        int stop;
        int op;
        int n;
        logic [31:0] w;
        logic [7:0]  lb;
        stop = byte_q.size() + count;
        while (byte_q.size() < stop) begin
            op = $urandom_range(17);
            if (op == 15) begin
                push_byte(BinStart);
            end else if (op == 16) begin
                push_byte(8'($urandom_range(8'h10, 8'h7F)));
            end else if (op == 17) begin
                // unknown opcode: the parser keeps waiting for an opcode
                push_byte(CmdStart);
                push_byte(8'($urandom_range(15, 255)));
                push_byte(OP_KEEP);
            end else begin
                push_byte(CmdStart);
                push_byte(8'(op));
                case (8'(op))
                    OP_SEND, OP_ECHO: begin
                        w = $urandom();
                        for (int k = 0; k < 4; k++) push_byte(w[8 * k +: 8]);
                        push_byte(8'($urandom_range(255)));
                        lb = 8'($urandom_range(255));
                        push_byte(lb);
                        n = (lb[3:0] > 8) ? 8 : int'(lb[3:0]);
                        for (int k = 0; k < n; k++) push_byte(8'($urandom_range(255)));
                        push_byte(8'($urandom_range(255)));
                    end
                    OP_TIME, OP_SKIP4, OP_SKIP8, OP_SYSTYPE:
                        push_byte(8'($urandom_range(255)));
                    OP_BUSSET: begin
                        for (int j = 0; j < 2; j++) begin
                            w = bus_word();
                            for (int k = 0; k < 4; k++) push_byte(w[8 * k +: 8]);
                        end
                    end
                    OP_EXTSKIP: begin
                        repeat (12) push_byte(8'($urandom_range(255)));
                    end
                    default: ;
                endcase
            end
        end
    endtask

    // send all queued bytes, holding each request until it is accepted
    task automatic send_bytes();
        while (byte_q.size() > 0) begin
            @(negedge i_clk);
            if ($urandom_range(99) < send_idle_pct) begin
                in_ch.valid = 1'b0;
            end else begin
                in_ch.payload = byte_q.pop_front();
                in_ch.valid = 1'b1;
                @(posedge i_clk);
                while (!in_ch.ready) @(posedge i_clk);
            end
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0 || out_ch.valid) @(negedge i_clk);
    endtask

    initial begin
        sb = new();
        sb.clear_state();
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1;

        reg_write(REG_BUILD, 32'($urandom_range(65535)));
        send_idle_pct = 24; recv_idle_pct = 53;
        gen_commands(53);
        send_bytes();
        drain();

        reg_write(REG_BUSCNT, 32'd1);
        send_idle_pct = 53; recv_idle_pct = 24;
        gen_commands(53);
        send_bytes();
        drain();

        reg_write(REG_BUSCNT, 32'($urandom_range(2, 4)));
        reg_write(REG_BUILD, 32'($urandom_range(65535)));
        send_idle_pct = 0; recv_idle_pct = 0;
        gen_commands(54);
        send_bytes();
        drain();

        if (sb.errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

### filelist.f
src/cscp_pkg.sv
src/cscp_if.sv
src/can_serial_command_parser.sv
sim/can_serial_command_parser_tb.sv
